### rtl/core/cwd_pkg.sv
// Shared types, constants and the CRC-8 fold function of the word deframer.
package cwd_pkg;

  localparam int DATA_BYTES_DEFAULT = 2;
  localparam int CMD_FIFO_DEPTH     = 2;

  localparam logic [7:0] CRC_START  = 8'hFF;
  localparam logic [7:0] POLY_RESET = 8'h31;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_CRC_ERR = 2'd1,
    STATUS_LEN_ERR = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    status_t    status;
    logic       last_of_run;
  } out_item_t;

  // Folds one byte into an MSB-first CRC-8; the top bit of the polynomial is implied.
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data,
                                           input logic [7:0] poly);
    logic [7:0] v;
    v = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ poly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

### rtl/core/cwd_front.sv
// Front end: accepts bytes, tracks group position and CRC, and queues group commands.
module cwd_front #(
  parameter int DATA_BYTES = cwd_pkg::DATA_BYTES_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  cwd_pkg::in_item_t         rx_item,
  input  logic                      cfg_valid,
  input  logic [7:0]                cfg_data,
  input  logic                      cmd_full,
  output logic                      cmd_push,
  output cwd_pkg::status_t          cmd_status,
  output logic [DATA_BYTES*8-1:0]   cmd_data
);

  localparam int PW = $clog2(DATA_BYTES + 1);
  localparam int IW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
  localparam logic [PW-1:0] LAST_POS = PW'(DATA_BYTES);

  logic [7:0]    poly;
  logic [PW-1:0] pos;
  logic [7:0]    crc;
  logic          discarding;
  logic [7:0]    held [DATA_BYTES];

  logic          accept;
  logic          at_crc_byte;
  logic          crc_match;

  assign accept      = push && !cmd_full;
  assign at_crc_byte = (pos == LAST_POS);
  assign crc_match   = (crc == rx_item.rx_byte);

  always_comb begin
    for (int i = 0; i < DATA_BYTES; i++) begin
      cmd_data[i*8 +: 8] = held[i];
    end
  end

  always_comb begin
    cmd_push   = 1'b0;
    cmd_status = cwd_pkg::STATUS_OK;
    if (accept && !discarding) begin
      if (at_crc_byte) begin
        cmd_push   = 1'b1;
        cmd_status = crc_match ? cwd_pkg::STATUS_OK : cwd_pkg::STATUS_CRC_ERR;
      end else if (rx_item.frame_end) begin
        cmd_push   = 1'b1;
        cmd_status = cwd_pkg::STATUS_LEN_ERR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poly       <= cwd_pkg::POLY_RESET;
      pos        <= '0;
      crc        <= cwd_pkg::CRC_START;
      discarding <= 1'b0;
    end else begin
      if (cfg_valid) begin
        poly <= cfg_data;
      end
      if (accept) begin
        if (discarding) begin
          if (rx_item.frame_end) begin
            discarding <= 1'b0;
            pos        <= '0;
            crc        <= cwd_pkg::CRC_START;
          end
        end else if (at_crc_byte) begin
          pos        <= '0;
          crc        <= cwd_pkg::CRC_START;
          discarding <= !crc_match && !rx_item.frame_end;
        end else if (rx_item.frame_end) begin
          pos <= '0;
          crc <= cwd_pkg::CRC_START;
        end else begin
          pos <= pos + PW'(1);
          crc <= cwd_pkg::crc8_fold(crc, rx_item.rx_byte, poly);
        end
      end
    end
  end

  // Held bytes carry no reset; each is written before the CRC byte of its group reads it.
  always_ff @(posedge clk) begin
    if (accept && !discarding && !at_crc_byte) begin
      held[pos[IW-1:0]] <= rx_item.rx_byte;
    end
  end

endmodule

### rtl/core/cwd_cmd_fifo.sv
// Short register queue that carries group commands from the front to the back end.
module cwd_cmd_fifo #(
  parameter int WIDTH = 18,
  parameter int DEPTH = cwd_pkg::CMD_FIFO_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  logic do_wr;
  logic do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

### rtl/core/cwd_back.sv
// Back end: turns one group command into its result items, one item per cycle while pop is high.
module cwd_back #(
  parameter int DATA_BYTES = cwd_pkg::DATA_BYTES_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cmd_empty,
  input  cwd_pkg::status_t        cmd_status,
  input  logic [DATA_BYTES*8-1:0] cmd_data,
  output logic                    cmd_pop,
  output logic                    empty,
  input  logic                    pop,
  output cwd_pkg::out_item_t      result_item
);

  localparam int IW = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(DATA_BYTES - 1);

  logic                    busy;
  cwd_pkg::status_t        status;
  logic [DATA_BYTES*8-1:0] data;
  logic [IW-1:0]           idx;

  logic is_last;
  logic taken;

  assign is_last = (status != cwd_pkg::STATUS_OK) || (idx == LAST_IDX);
  assign taken   = busy && pop;
  // A new command loads when the current one is gone or its final item leaves now.
  assign cmd_pop = !cmd_empty && (!busy || (taken && is_last));
  assign empty   = !busy;

  always_comb begin
    result_item.payload_byte = (status == cwd_pkg::STATUS_OK) ? data[idx*8 +: 8] : 8'd0;
    result_item.status       = status;
    result_item.last_of_run  = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      if (cmd_pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (taken) begin
        if (is_last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      status <= cmd_status;
      data   <= cmd_data;
    end
  end

endmodule

### rtl/core/crc_checked_word_deframer.sv
// Top level of the CRC-checked word deframer: front end, command queue and back end.
//
// Input channel: push/full. A byte is accepted at a rising edge with push high and
// full low; frame_end marks the last byte of a frame. Each group is DATA_BYTES data
// bytes followed by one CRC-8 byte (MSB first, start 0xFF, polynomial from the
// configuration register, which resets to 0x31 and is written through cfg_valid /
// cfg_ready / cfg_data; cfg_ready is always high).
// Result channel: empty/pop. The oldest result sits on result_item while empty is
// low and leaves at an edge with pop high. A good group gives DATA_BYTES items, a
// CRC mismatch or a short frame one error item; last_of_run flags the final item.
// Throughput: one byte per cycle while full is low. A result waits until its command
// is written into the queue and then loaded into the back end; the back end drains
// one item per cycle while pop is high, which group length always leaves room for.
// When the receiver stalls, finished commands wait in a two-entry queue; once it is
// full, full rises and input waits. Synchronous reset empties the queue, clears the
// group state and restores the polynomial.
module crc_checked_word_deframer #(
  parameter int DATA_BYTES = cwd_pkg::DATA_BYTES_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  cwd_pkg::in_item_t  rx_item,
  output logic               empty,
  input  logic               pop,
  output cwd_pkg::out_item_t result_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  localparam int CMD_W = 2 + DATA_BYTES * 8;

  logic                    cmd_push;
  logic                    cmd_full;
  cwd_pkg::status_t        front_status;
  logic [DATA_BYTES*8-1:0] front_data;
  logic                    cmd_pop;
  logic                    cmd_empty;
  logic [CMD_W-1:0]        fifo_rd;

  assign full      = cmd_full;
  assign cfg_ready = 1'b1;

  cwd_front #(
    .DATA_BYTES (DATA_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .rx_item    (rx_item),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .cmd_full   (cmd_full),
    .cmd_push   (cmd_push),
    .cmd_status (front_status),
    .cmd_data   (front_data)
  );

  cwd_cmd_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (cwd_pkg::CMD_FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_push),
    .wr_data ({front_status, front_data}),
    .full    (cmd_full),
    .rd_en   (cmd_pop),
    .rd_data (fifo_rd),
    .empty   (cmd_empty)
  );

  cwd_back #(
    .DATA_BYTES (DATA_BYTES)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_empty   (cmd_empty),
    .cmd_status  (cwd_pkg::status_t'(fifo_rd[CMD_W-1 -: 2])),
    .cmd_data    (fifo_rd[DATA_BYTES*8-1:0]),
    .cmd_pop     (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .result_item (result_item)
  );

endmodule
